// ----- hdl/bes_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bes_pkg;

  localparam int DEPTH  = 32;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_SORT_CHECK,
    ST_SORT_CMP,
    ST_SORT_WB,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic store;       // write accepted item into the store
    logic sort_init;   // clear scan position, bookmark, sink flag and emit index
    logic cmp_step;    // compare the pair read at scan position, swap first half
    logic swap_wb;     // write the second half of a swap
    logic emit_sel;    // read port a follows the emit index
    logic emit_load;   // load the output register
    logic clear_list;  // list done, back to empty
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sort_more;   // pair at scan position lies inside the list
    logic greater;     // pair at scan position is inverted
    logic out_free;    // output register can take a new result
    logic emit_last;   // emit index points at the last element
  } status_t;

endpackage

`default_nettype wire

// ----- hdl/bes_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface bes_in_if import bes_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t value;
  logic  final_req;

  modport source (output valid, output value, output final_req, input ready);
  modport sink   (input valid, input value, input final_req, output ready);
endinterface

interface bes_out_if import bes_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t sorted_value;
  logic  end_of_list;
  logic  overflowed;

  modport source (output valid, output sorted_value, output end_of_list,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input end_of_list,
                  input overflowed, output ready);
endinterface

`default_nettype wire

// ----- hdl/bes_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output      logic [WIDTH-1:0]         rd_data_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output      logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

// ----- hdl/bes_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bes_ctrl import bes_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    in_final,
  output      logic    in_ready,
  input  wire status_t status,
  output      cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_COLLECT: begin
        in_ready      = 1'b1;
        cmd.store     = in_valid;
        cmd.sort_init = in_valid && in_final;
        if (in_valid && in_final) begin
          state_next = ST_SORT_CHECK;
        end
      end
      ST_SORT_CHECK: begin
        // pair read is issued here, data is ready in the compare state
        state_next = status.sort_more ? ST_SORT_CMP : ST_EMIT_RD;
      end
      ST_SORT_CMP: begin
        cmd.cmp_step = 1'b1;
        state_next   = status.greater ? ST_SORT_WB : ST_SORT_CHECK;
      end
      ST_SORT_WB: begin
        cmd.swap_wb = 1'b1;
        state_next  = ST_SORT_CHECK;
      end
      ST_EMIT_RD: begin
        cmd.emit_sel = 1'b1;
        state_next   = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        cmd.emit_sel = 1'b1;
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          if (status.emit_last) begin
            cmd.clear_list = 1'b1;
            state_next     = ST_COLLECT;
          end else begin
            state_next = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = ST_COLLECT;
      end
    endcase
  end

`ifndef SYNTH
  a_leave_collect_on_final: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == ST_COLLECT && state != ST_COLLECT) |-> $past(in_valid && in_final))
    else $error("collection ended without a final transaction");

  a_swap_pairs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SORT_WB) |-> ($past(state) == ST_SORT_CMP && $past(status.greater)))
    else $error("swap write-back without an inverted pair");
`endif

endmodule

`default_nettype wire

// ----- hdl/bes_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bes_dpath import bes_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cmd_t    cmd,
  output      status_t status,
  input  wire data_t   in_value,
  input  wire logic    out_ready,
  output      logic    out_valid,
  output      data_t   out_value,
  output      logic    out_eol,
  output      logic    out_ovf
);

  cnt_t  count;
  addr_t pos;
  addr_t mark;
  logic  sink;
  logic  drop;
  addr_t k;
  addr_t hold_addr;
  data_t hold_val;

  logic  wr_en;
  addr_t wr_addr;
  data_t wr_data;
  addr_t rd_addr_a;
  addr_t rd_addr_b;
  data_t rd_a;
  data_t rd_b;
  logic  has_room;

  assign has_room  = (count < cnt_t'(DEPTH));
  assign rd_addr_a = cmd.emit_sel ? k : pos;
  assign rd_addr_b = pos + addr_t'(1);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[ADDR_W-1:0];
    wr_data = in_value;
    priority if (cmd.store) begin
      wr_en = has_room;
    end else if (cmd.cmp_step) begin
      wr_en   = status.greater;
      wr_addr = pos;
      wr_data = rd_b;
    end else if (cmd.swap_wb) begin
      wr_en   = 1'b1;
      wr_addr = hold_addr;
      wr_data = hold_val;
    end
  end

  assign status.sort_more = (({1'b0, pos} + cnt_t'(1)) < count);
  assign status.greater   = (rd_a > rd_b);
  assign status.out_free  = !out_valid || out_ready;
  assign status.emit_last = (({1'b0, k} + cnt_t'(1)) == count);

  bes_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr_a(rd_addr_a),
    .rd_data_a(rd_a),
    .rd_addr_b(rd_addr_b),
    .rd_data_b(rd_b)
  );

  // list bookkeeping and sort scan state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_list) begin
      count <= '0;
      drop  <= 1'b0;
      pos   <= '0;
      mark  <= '0;
      sink  <= 1'b0;
      k     <= '0;
    end else begin
      if (cmd.store) begin
        if (has_room) begin
          count <= count + cnt_t'(1);
        end else begin
          drop <= 1'b1;
        end
      end
      if (cmd.sort_init) begin
        pos  <= '0;
        mark <= '0;
        sink <= 1'b0;
        k    <= '0;
      end
      if (cmd.cmp_step) begin
        priority if (status.greater) begin
          if (!sink) begin
            mark <= pos;
          end
          sink <= 1'b1;
          pos  <= (pos != '0) ? pos - addr_t'(1) : addr_t'(1);
        end else if (sink) begin
          pos  <= mark + addr_t'(1);
          sink <= 1'b0;
        end else begin
          pos <= pos + addr_t'(1);
        end
      end
      if (cmd.emit_load) begin
        k <= k + addr_t'(1);
      end
    end
  end

  // second half of a swap
  always_ff @(posedge clk) begin
    if (cmd.cmp_step) begin
      hold_addr <= pos + addr_t'(1);
      hold_val  <= rd_a;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_value <= rd_a;
      out_eol   <= status.emit_last;
      out_ovf   <= drop;
    end
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> (!out_valid || out_ready))
    else $error("result register loaded while holding a pending result");

  a_emit_in_list: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> (({1'b0, k} < count) && (count <= cnt_t'(DEPTH))))
    else $error("emit index outside the stored list");

  a_idle_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> (!sink && pos == '0 && k == '0))
    else $error("scan state not cleared while collecting");
`endif

endmodule

`default_nettype wire

// ----- hdl/bookmark_exchange_sorter_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// bookmark exchange sorter: signed 32-bit values arrive one transaction per
// cycle on items while collecting and are kept in a 32-entry store (one
// store write per kept transaction); a transaction with final_req high closes
// the list. values beyond 32 are dropped and every result of that list then
// carries overflowed. the list is sorted ascending in place by an exchange
// scan with a bookmark: each neighbour compare is a registered ram read of the
// pair, then the compare, and each swap adds a write-back step because the
// single ram write port writes the two halves in turn. results then leave
// through an output register, each one read, then loaded, the last one flagged
// by end_of_list. items stays low from the final transaction until the last
// result is loaded into the output register; the next list may be collected
// while that last result waits to be taken.
module bookmark_exchange_sorter_top import bes_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  bes_in_if.sink    items,
  bes_out_if.source results
);

  cmd_t    cmd;
  status_t status;

  // sequencer: collect, sort scan, emit
  bes_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(items.valid),
    .in_final(items.final_req),
    .in_ready(items.ready),
    .status  (status),
    .cmd     (cmd)
  );

  // element store, scan registers and result register
  bes_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_value (items.value),
    .out_ready(results.ready),
    .out_valid(results.valid),
    .out_value(results.sorted_value),
    .out_eol  (results.end_of_list),
    .out_ovf  (results.overflowed)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import bes_pkg::*;

  localparam int RAND_ITEMS   = 135;     // random stimulus stops once at least this many transactions were sent
  localparam int IDLE_PCT     = 28;      // chance in percent that a side idles on a cycle
  localparam int MAX_REPORTS  = 10;      // mismatches printed in full
  localparam int DRAIN_CYCLES = 100;     // quiet window after the last expected result
  localparam int CYCLE_LIMIT  = 600000;  // hard stop, several times the slowest clean run

  // one sorted element as it should leave the block
  typedef struct packed {
    data_t value;
    logic  end_flag;
    logic  ovf_flag;
  } sorted_entry_t;

  // one row of the directed table: reps transactions, value stepping by step,
  // final_req on the last one when fin is set; typed rows are single-element lists whose
  // result is written straight into the table
  typedef struct packed {
    data_t value;
    int    step;
    int    reps;
    logic  fin;
    logic  typed;
    logic  typed_ovf;
  } stim_row_t;

  localparam int NUM_ROWS = 23;
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // single elements straight after reset: the value comes back unchanged
    '{32'sd0,           0,   1,  1'b1, 1'b1, 1'b0},
    '{32'sh7fffffff,    0,   1,  1'b1, 1'b1, 1'b0},
    '{32'sh80000000,    0,   1,  1'b1, 1'b1, 1'b0},
    '{-32'sd1,          0,   1,  1'b1, 1'b1, 1'b0},
    // two extremes, inverted, so the signed compare must swap them
    '{32'sh7fffffff,    0,   1,  1'b0, 1'b0, 1'b0},
    '{32'sh80000000,    0,   1,  1'b1, 1'b0, 1'b0},
    // equal pair, strict compare leaves it alone
    '{32'sd5,           0,   2,  1'b1, 1'b0, 1'b0},
    // fully reversed: every step sinks back to the head of the list
    '{32'sd7,          -1,   8,  1'b1, 1'b0, 1'b0},
    // already sorted
    '{-32'sd3,          1,   6,  1'b1, 1'b0, 1'b0},
    // reversed across zero
    '{32'sd3,          -2,   5,  1'b1, 1'b0, 1'b0},
    // store exactly full, no drop
    '{32'sd1000,      -17,  32,  1'b1, 1'b0, 1'b0},
    // store full, then the final mark itself is dropped
    '{-32'sd40,         3,  32,  1'b0, 1'b0, 1'b0},
    '{32'sd99,          0,   1,  1'b1, 1'b0, 1'b0},
    // drop flag must be clear on the next list
    '{32'sd42,          0,   1,  1'b1, 1'b1, 1'b0},
    // several drops before the final mark
    '{32'sd50,         -1,  34,  1'b0, 1'b0, 1'b0},
    '{-32'sd7,          0,   1,  1'b1, 1'b0, 1'b0},
    '{32'sh5555aaaa,    0,   1,  1'b1, 1'b1, 1'b0},
    // duplicates mixed with both extremes
    '{32'sd10,          0,   1,  1'b0, 1'b0, 1'b0},
    '{-32'sd20,         0,   1,  1'b0, 1'b0, 1'b0},
    '{32'sh7fffffff,    0,   1,  1'b0, 1'b0, 1'b0},
    '{32'sh80000000,    0,   1,  1'b0, 1'b0, 1'b0},
    '{32'sd10,          0,   1,  1'b0, 1'b0, 1'b0},
    '{-32'sd20,         0,   1,  1'b1, 1'b0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst;
  bit   no_idle;       // long stretch with both sides always ready to move
  int   mismatches;
  int   cycle_count;

  // predictor state: the list being collected
  data_t         list_mem [DEPTH];
  int            list_len;
  bit            list_dropped;
  sorted_entry_t pending_sorted [$];

  bes_in_if  items_if ();
  bes_out_if results_if ();

  bookmark_exchange_sorter_top uut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // exchange sort with a bookmark, same visiting order as the hardware scan;
  // after a swap the scan steps back one pair to sink the moved element, the
  // first pair found in order sends it back to just past the bookmark
  function automatic void sort_list();
    int unsigned pos;
    int unsigned mark;
    bit          sinking;
    data_t       tmp;
    pos     = 0;
    mark    = 0;
    sinking = 1'b0;
    while (pos + 1 < list_len) begin
      if (list_mem[pos] > list_mem[pos + 1]) begin
        if (!sinking) mark = pos;
        sinking           = 1'b1;
        tmp               = list_mem[pos];
        list_mem[pos]     = list_mem[pos + 1];
        list_mem[pos + 1] = tmp;
        pos               = (pos > 0) ? pos - 1 : 1;
      end else if (sinking) begin
        pos     = mark + 1;
        sinking = 1'b0;
      end else begin
        pos = pos + 1;
      end
    end
  endfunction

  // store one accepted element; a final mark sorts the list and queues its results
  function automatic void take_element(data_t v, logic fin);
    sorted_entry_t e;
    if (list_len < DEPTH) begin
      list_mem[list_len] = v;
      list_len++;
    end else begin
      list_dropped = 1'b1;
    end
    if (fin) begin
      sort_list();
      for (int k = 0; k < list_len; k++) begin
        e.value    = list_mem[k];
        e.end_flag = (k == list_len - 1);
        e.ovf_flag = list_dropped;
        pending_sorted.push_back(e);
      end
      list_len     = 0;
      list_dropped = 1'b0;
    end
  endfunction

  // one input transaction; entered and left at a falling edge.
  // typed rows queue the result written in the table instead of the predictor's
  task automatic send_item(input data_t v, input logic fin, input logic typed,
                           input logic typed_ovf);
    sorted_entry_t e;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      items_if.valid = 1'b0;
      @(negedge clk);
    end
    items_if.valid     = 1'b1;
    items_if.value     = v;
    items_if.final_req = fin;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    // accepted at this edge
    if (typed) begin
      e.value    = v;
      e.end_flag = 1'b1;
      e.ovf_flag = typed_ovf;
      pending_sorted.push_back(e);
    end else begin
      take_element(v, fin);
    end
    @(negedge clk);
  endtask

  // hold the sender until every queued result has come out
  task automatic drain_results();
    items_if.valid = 1'b0;
    while (pending_sorted.size() != 0) @(negedge clk);
  endtask

  // random element of one of a few shapes: full range, tight range with many
  // duplicates, a descending run, or the extremes and values around zero
  function automatic data_t pick_value(int shape, int k, data_t base);
    data_t v;
    case (shape)
      0: v = data_t'($urandom);
      1: v = data_t'(int'($urandom_range(0, 15)) - 8);
      2: v = data_t'(base - k * 3);
      default: begin
        case ($urandom_range(0, 4))
          0: v = 32'sh7fffffff;
          1: v = 32'sh80000000;
          2: v = '0;
          3: v = -32'sd1;
          default: v = 32'sd1;
        endcase
      end
    endcase
    return v;
  endfunction

  // receiver: stalls at random, never during the no-idle stretch
  initial begin
    results_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      results_if.ready = rst ? 1'b0 : (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // result checker: each result against the oldest expectation
  always @(posedge clk) begin : check_results
    sorted_entry_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (pending_sorted.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result: value %0d end %0b ovf %0b",
                   results_if.sorted_value, results_if.end_of_list,
                   results_if.overflowed);
        mismatches++;
      end else begin
        want = pending_sorted.pop_front();
        if (results_if.sorted_value !== want.value ||
            results_if.end_of_list !== want.end_flag ||
            results_if.overflowed !== want.ovf_flag) begin
          if (mismatches < MAX_REPORTS)
            $display({"mismatch: expected value %0d end %0b ovf %0b, ",
                      "got value %0d end %0b ovf %0b"},
                     want.value, want.end_flag, want.ovf_flag,
                     results_if.sorted_value, results_if.end_of_list,
                     results_if.overflowed);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_sorted.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t row;
    int        rand_items;
    int        len;
    int        shape;
    int        sel;
    data_t     base;
    data_t     v;
    bit        paused_mid;

    rst                = 1'b1;
    no_idle            = 1'b0;
    mismatches         = 0;
    cycle_count        = 0;
    list_len           = 0;
    list_dropped       = 1'b0;
    items_if.valid     = 1'b0;
    items_if.value     = '0;
    items_if.final_req = 1'b0;
    paused_mid         = 1'b0;
    rand_items         = 0;

    // reset held, then released at a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    for (int r = 0; r < NUM_ROWS; r++) begin
      row = DIRECTED_ROWS[r];
      for (int k = 0; k < row.reps; k++)
        send_item(data_t'(row.value + k * row.step), row.fin && (k == row.reps - 1),
                  row.typed, row.typed_ovf);
    end

    // sender waits for the whole directed part to come out
    drain_results();

    // random lists: mostly short, some exactly full, a few overflowing
    while (rand_items < RAND_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 6)
        len = $urandom_range(DEPTH + 1, DEPTH + 8);
      else if (sel < 12)
        len = DEPTH;
      else if (sel < 30)
        len = $urandom_range(1, 3);
      else
        len = $urandom_range(2, 12);
      shape = $urandom_range(0, 3);
      base  = data_t'($urandom);

      // the middle of the run goes without idling on either side
      no_idle = (rand_items >= 40 && rand_items < 95);

      for (int k = 0; k < len; k++) begin
        v = pick_value(shape, k, base);
        send_item(v, k == len - 1, 1'b0, 1'b0);
      end
      rand_items += len;

      // second hold-off, somewhere in the random part
      if (!paused_mid && rand_items >= 100) begin
        paused_mid = 1'b1;
        drain_results();
      end
    end

    no_idle = 1'b0;
    drain_results();
    // anything extra would show up in this window
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (pending_sorted.size() != 0) begin
      $display("%0d results never arrived", pending_sorted.size());
      mismatches += pending_sorted.size();
    end
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
